// ===== rtl/serial_rtc_date_reader_assert.svh =====
// ----------------------------------------------------------------------------
// serial rtc date reader assertion macros
// shared concurrent assertion forms for the rtl files
// ----------------------------------------------------------------------------
`ifndef SERIAL_RTC_DATE_READER_ASSERT_SVH
`define SERIAL_RTC_DATE_READER_ASSERT_SVH

// same-cycle implication
`define SRDR_ASSERT_NOW(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRDR_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/srdr_pkg.sv =====
// ----------------------------------------------------------------------------
// srdr_pkg
// shared types and constants of the serial rtc date reader
// ----------------------------------------------------------------------------
`default_nettype none

package srdr_pkg;

	localparam int DATE_BYTES = 7;
	localparam int YEAR_W     = 12;
	localparam int CFG_IDX_W  = 2;

	localparam logic [7:0] CMD_STATUS_READ = 8'h63;
	localparam logic [7:0] CMD_DATE_READ   = 8'h65;
	localparam int         STATUS_24H_BIT  = 6;

	// byte destination that selects the status register
	localparam logic [2:0] DEST_STATUS = 3'd7;

	localparam logic [YEAR_W-1:0] YEAR_BASE     = 12'd2000;
	localparam logic [YEAR_W-1:0] YEAR_MIN_INIT = 12'd2020;
	localparam logic [YEAR_W-1:0] YEAR_MAX_INIT = 12'd2049;

	localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_YEAR_MAX = 2'd1;

	typedef enum logic [1:0] {
		RES_NONE     = 2'd0,
		RES_VALID    = 2'd1,
		RES_NO_CLOCK = 2'd2
	} res_code_t;

	typedef logic [DATE_BYTES-1:0][7:0] raw_date_t;

	typedef struct packed {
		logic sck;
		logic cs;
		logic sio_out;
		logic sio_drive;
		logic eval;
	} pin_t;

	typedef struct packed {
		res_code_t         code;
		logic [YEAR_W-1:0] year;
		logic [3:0]        month;
		logic [4:0]        day;
		logic [2:0]        weekday;
		logic [4:0]        hour;
		logic [5:0]        minute;
		logic [5:0]        second;
	} date_t;

endpackage

`default_nettype wire

// ===== rtl/srdr_seq.sv =====
// ----------------------------------------------------------------------------
// srdr_seq
// bus sequencer: pin levels per tick, bit and byte counting, byte capture
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_rtc_date_reader_assert.svh"

module srdr_seq
	import srdr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire logic      start_req,
	input  wire logic      sio_in,
	output pin_t           pins,
	output logic [7:0]     status,
	output raw_date_t      raw_date
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETUP,
		PH_CMD,
		PH_READ,
		PH_TAIL
	} phase_t;

	phase_t     phase_q, ph_cur, ph_n;
	logic       second_q, sec_cur, sec_n;
	logic [2:0] tick_q, tick_cur, tick_n;
	logic [2:0] bit_q, bit_n;
	logic [2:0] byte_q, byte_n, byte_inc, read_len;
	logic       pend_q, pend_n;
	logic       pend_done_q, pend_done_n;
	logic [2:0] pend_dest_q, pend_dest_n;
	logic [7:0] shift_q, shift_n, cmd;
	logic [7:0] status_q;
	raw_date_t  raw_q;

	assign shift_n  = pend_q ? {sio_in, shift_q[7:1]} : shift_q;
	assign byte_inc = byte_q + 3'd1;

	always_comb begin
		pins     = '0;
		ph_cur   = phase_q;
		sec_cur  = second_q;
		tick_cur = tick_q;
		if (phase_q == PH_IDLE) begin
			if (start_req) begin
				ph_cur   = PH_SETUP;
				sec_cur  = 1'b0;
				tick_cur = 3'd0;
			end else begin
				pins.sck = 1'b1;
			end
		end
		ph_n        = ph_cur;
		sec_n       = sec_cur;
		tick_n      = tick_cur;
		bit_n       = bit_q;
		byte_n      = byte_q;
		pend_n      = 1'b0;
		pend_done_n = pend_done_q;
		pend_dest_n = pend_dest_q;
		cmd         = sec_cur ? CMD_DATE_READ : CMD_STATUS_READ;
		read_len    = sec_cur ? 3'(DATE_BYTES) : 3'd1;
		case (ph_cur)
			PH_SETUP: begin
				pins.sck       = 1'b1;
				pins.sio_drive = 1'b1;
				if (tick_cur == 3'd0) begin
					tick_n = 3'd1;
				end else begin
					pins.cs = 1'b1;
					ph_n    = PH_CMD;
					tick_n  = 3'd0;
					bit_n   = 3'd0;
				end
			end
			PH_CMD: begin
				pins.cs        = 1'b1;
				pins.sio_drive = 1'b1;
				pins.sio_out   = cmd[~bit_q];
				if (tick_cur >= 3'd3) begin
					pins.sck = 1'b1;
					tick_n   = 3'd0;
					if (bit_q == 3'd7) begin
						ph_n   = PH_READ;
						bit_n  = 3'd0;
						byte_n = 3'd0;
					end else begin
						bit_n = bit_q + 3'd1;
					end
				end else begin
					tick_n = tick_cur + 3'd1;
				end
			end
			PH_READ: begin
				pins.cs = 1'b1;
				if (tick_cur >= 3'd5) begin
					pins.sck    = 1'b1;
					pend_n      = 1'b1;
					pend_done_n = (bit_q == 3'd7);
					pend_dest_n = sec_cur ? byte_q : DEST_STATUS;
					tick_n      = 3'd0;
					if (bit_q == 3'd7) begin
						bit_n  = 3'd0;
						byte_n = byte_inc;
						if (byte_inc >= read_len) begin
							ph_n = PH_TAIL;
						end
					end else begin
						bit_n = bit_q + 3'd1;
					end
				end else begin
					tick_n = tick_cur + 3'd1;
				end
			end
			PH_TAIL: begin
				pins.sck = 1'b1;
				if (tick_cur == 3'd0) begin
					tick_n = 3'd1;
				end else if (!sec_cur) begin
					sec_n  = 1'b1;
					ph_n   = PH_SETUP;
					tick_n = 3'd0;
				end else begin
					pins.eval = 1'b1;
					ph_n      = PH_IDLE;
					tick_n    = 3'd0;
					sec_n     = 1'b0;
					bit_n     = 3'd0;
					byte_n    = 3'd0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			second_q    <= 1'b0;
			tick_q      <= 3'd0;
			bit_q       <= 3'd0;
			byte_q      <= 3'd0;
			pend_q      <= 1'b0;
			pend_done_q <= 1'b0;
			pend_dest_q <= 3'd0;
		end else if (step) begin
			phase_q     <= ph_n;
			second_q    <= sec_n;
			tick_q      <= tick_n;
			bit_q       <= bit_n;
			byte_q      <= byte_n;
			pend_q      <= pend_n;
			pend_done_q <= pend_done_n;
			pend_dest_q <= pend_dest_n;
		end
	end

	// received bytes land here
	always_ff @(posedge clk) begin
		if (step) begin
			shift_q <= shift_n;
			if (pend_q && pend_done_q) begin
				if (pend_dest_q == DEST_STATUS) begin
					status_q <= shift_n;
				end else begin
					raw_q[pend_dest_q] <= shift_n;
				end
			end
		end
	end

	assign status   = status_q;
	assign raw_date = raw_q;

	`SRDR_ASSERT_NOW(a_cmd_tick, clk, arst_n, phase_q == PH_CMD, tick_q <= 3'd3, "cmd tick out of range")
	`SRDR_ASSERT_NOW(a_read_tick, clk, arst_n, phase_q == PH_READ, tick_q <= 3'd5, "read tick out of range")
	`SRDR_ASSERT_NOW(a_pend_phase, clk, arst_n, pend_q, phase_q == PH_READ || phase_q == PH_TAIL, "sample pending outside read")
	`SRDR_ASSERT_NEXT(a_eval_idle, clk, arst_n, step && pins.eval, phase_q == PH_IDLE && !second_q, "no return to idle after check")

endmodule

`default_nettype wire

// ===== rtl/srdr_eval.sv =====
// ----------------------------------------------------------------------------
// srdr_eval
// date check: bcd digits, field limits, 24-hour status and year window
// ----------------------------------------------------------------------------
`default_nettype none

module srdr_eval
	import srdr_pkg::*;
(
	input  wire logic [7:0]        status,
	input  wire raw_date_t         raw_date,
	input  wire logic [YEAR_W-1:0] year_min,
	input  wire logic [YEAR_W-1:0] year_max,
	output date_t                  res
);

	function automatic logic digits_ok(input logic [7:0] b);
		digits_ok = (b[3:0] <= 4'd9) && (b[7:4] <= 4'd9);
	endfunction

	function automatic logic [6:0] bcd_value(input logic [7:0] b);
		bcd_value = {b[7:4], 3'b000} + {2'b00, b[7:4], 1'b0} + {3'b000, b[3:0]};
	endfunction

	logic [7:0]        b_wd, b_hr, b_sc;
	logic [6:0]        y, mo, d, wd, h, mi, s;
	logic              fields_ok, year_ok;
	logic [YEAR_W-1:0] full;

	assign b_wd = {5'b0, raw_date[3][2:0]};
	assign b_hr = {2'b0, raw_date[4][5:0]};
	assign b_sc = {1'b0, raw_date[6][6:0]};

	assign y  = bcd_value(raw_date[0]);
	assign mo = bcd_value(raw_date[1]);
	assign d  = bcd_value(raw_date[2]);
	assign wd = bcd_value(b_wd);
	assign h  = bcd_value(b_hr);
	assign mi = bcd_value(raw_date[5]);
	assign s  = bcd_value(b_sc);

	assign fields_ok = status[STATUS_24H_BIT]
		&& digits_ok(raw_date[0]) && digits_ok(raw_date[1]) && digits_ok(raw_date[2])
		&& digits_ok(b_wd) && digits_ok(b_hr) && digits_ok(raw_date[5]) && digits_ok(b_sc)
		&& (mo <= 7'd12) && (mo != 7'd0) && (d <= 7'd31) && (d != 7'd0)
		&& (wd <= 7'd6) && (h <= 7'd23) && (mi <= 7'd59) && (s <= 7'd59);

	assign full    = YEAR_BASE + {{(YEAR_W-7){1'b0}}, y};
	assign year_ok = (full >= year_min) && (full <= year_max);

	always_comb begin
		res = '0;
		if (fields_ok && year_ok) begin
			res.code    = RES_VALID;
			res.year    = full;
			res.month   = mo[3:0];
			res.day     = d[4:0];
			res.weekday = wd[2:0];
			res.hour    = h[4:0];
			res.minute  = mi[5:0];
			res.second  = s[5:0];
		end else begin
			res.code = RES_NO_CLOCK;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/serial_rtc_date_reader.sv =====
// ----------------------------------------------------------------------------
// serial_rtc_date_reader
// reads status and date from a three-wire serial clock chip, one pin tick
// per request, and reports the checked date or no-clock
// path: input registers, then the sequencer update, then the result registers
// throughput: one request per cycle unless res_stall stalls a result, set by the
// input and result registers around the single-tick sequencer update
// reset: sequencer idle, year window back to 2020..2049, pipeline empty
// ----------------------------------------------------------------------------
`default_nettype none

module serial_rtc_date_reader
	import srdr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 tick_valid,
	output logic                      tick_stall,
	input  wire logic                 start_req,
	input  wire logic                 sio_in,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic                      sck,
	output logic                      cs,
	output logic                      sio_out,
	output logic                      sio_drive,
	output logic [1:0]                result_code,
	output logic [YEAR_W-1:0]         year,
	output logic [3:0]                month,
	output logic [4:0]                day,
	output logic [2:0]                weekday,
	output logic [4:0]                hour,
	output logic [5:0]                minute,
	output logic [5:0]                second,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [YEAR_W-1:0]    cfg_data
);

	logic              advance, step;
	logic              v_s1, v_s2;
	logic              start_s1, sio_s1;
	logic [YEAR_W-1:0] year_min_q, year_max_q;
	pin_t              pins, pins_s2;
	date_t             eval_res, res_s2;
	logic [7:0]        status;
	raw_date_t         raw_date;

	assign advance    = !v_s2 || !res_stall;
	assign tick_stall = !advance;
	assign step       = v_s1 && advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_min_q <= YEAR_MIN_INIT;
			year_max_q <= YEAR_MAX_INIT;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_YEAR_MIN) begin
				year_min_q <= cfg_data;
			end else if (cfg_index == CFG_YEAR_MAX) begin
				year_max_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= tick_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tick_valid) begin
			start_s1 <= start_req;
			sio_s1   <= sio_in;
		end
		if (step) begin
			pins_s2 <= pins;
			res_s2  <= pins.eval ? eval_res : '0;
		end
	end

	srdr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.start_req (start_s1),
		.sio_in    (sio_s1),
		.pins      (pins),
		.status    (status),
		.raw_date  (raw_date)
	);

	srdr_eval u_eval (
		.status   (status),
		.raw_date (raw_date),
		.year_min (year_min_q),
		.year_max (year_max_q),
		.res      (eval_res)
	);

	assign res_valid   = v_s2;
	assign sck         = pins_s2.sck;
	assign cs          = pins_s2.cs;
	assign sio_out     = pins_s2.sio_out;
	assign sio_drive   = pins_s2.sio_drive;
	assign result_code = res_s2.code;
	assign year        = res_s2.year;
	assign month       = res_s2.month;
	assign day         = res_s2.day;
	assign weekday     = res_s2.weekday;
	assign hour        = res_s2.hour;
	assign minute      = res_s2.minute;
	assign second      = res_s2.second;

endmodule

`default_nettype wire
